// ===== sv/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg: texture slot table shared types and constants
// Word formats, operation and result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package tst_pkg;

  localparam int DefSlots      = 64;
  localparam int DefHandleBits = 32;
  localparam int MaxRuns       = 32;
  localparam int RunCntW       = $clog2(MaxRuns + 1);
  localparam int HandleW       = 32;
  localparam int FrameW        = 32;
  localparam int FieldW        = 6;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_UPSERT = 2'd1,
    OP_END    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_ACK    = 2'd0,
    K_INDEX  = 2'd1,
    K_RANGE  = 2'd2,
    K_REJECT = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BEGIN,
    S_CLEAR,
    S_UP_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_UP_MISS,
    S_UP_POP,
    S_UP_WR,
    S_REJ,
    S_ES_INIT,
    S_ES_RD,
    S_ES_CHK,
    S_ES_CNT,
    S_ES_DEC,
    S_ES_NONE,
    S_ES_RUN,
    S_ES_FLUSH
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [HandleW-1:0]  handle;
    logic                handle_valid;
    logic                force_dirty;
    logic [FrameW-1:0]   frame_number;
  } in_t;

  typedef struct packed {
    kind_e               kind;
    logic [FieldW-1:0]   slot_index;
    logic [FieldW-1:0]   range_first;
    logic [FieldW-1:0]   range_count;
    logic [FieldW-1:0]   dirty_total;
    logic                last;
  } out_t;

  typedef struct packed {
    logic latch;
    logic do_begin;
    logic do_clear;
    logic scan_init;
    logic rd;
    logic inc;
    logic hit;
    logic pop;
    logic pop_take;
    logic grow;
    logic up_wr;
    logic emit_rej;
    logic es_chk;
    logic cnt_init;
    logic cnt_step;
    logic run_init;
    logic run_step;
    logic emit_none;
    logic emit_flush;
  } cmd_t;

  typedef struct packed {
    logic up_bad;
    logic scan_done;
    logic hmatch;
    logic free_nz;
    logic can_grow;
    logic at_end;
    logic total_zero;
    logic run_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/texture_slot_table_with_dirty_ranges_core.sv =====
// An upsert compares slots in order until a hit; a miss pops the free stack or grows
// the table. end_sync scans slots in use above slot 0, counts dirty marks over all
// slots, then builds runs; result words wait on output stalls. Ready only when idle.
// Reset: async active low; one slot in use, no free slots, frame 0, no dirty
// marks. Slot RAMs need no clearing pass: entries are written before read.
// ----------------------------------------------------------------------------
// texture_slot_table_with_dirty_ranges_core: texture slot table top level
// Maps nonzero handles to slots with frame stamping and reports dirty runs.
// ----------------------------------------------------------------------------
`default_nettype none
module texture_slot_table_with_dirty_ranges_core import tst_pkg::*; #(
  parameter int SLOTS       = DefSlots,
  parameter int HANDLE_BITS = DefHandleBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  cmd_t cmd;
  sts_t sts;

  tst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_op_i(in_data_i.op), .in_ready_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  tst_dp #(.SLOTS(SLOTS), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .sts_o(sts),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire

// ===== sv/tst_ram.sv =====
// ----------------------------------------------------------------------------
// tst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/tst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tst_ctrl: texture slot table controller
// Sequences begin_sync, upsert search/allocate, end_sync free/count/run
// passes and clear, issuing commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_ctrl import tst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire op_e  in_op_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (in_op_i)
            OP_BEGIN:  state_d = S_BEGIN;
            OP_UPSERT: state_d = S_UP_CHK;
            OP_END:    state_d = S_ES_INIT;
            OP_CLEAR:  state_d = S_CLEAR;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_BEGIN: begin
        if (sts_i.out_free) begin
          cmd_o.do_begin = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (sts_i.out_free) begin
          cmd_o.do_clear = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_UP_CHK: begin
        if (sts_i.up_bad) begin
          state_d = S_REJ;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (sts_i.scan_done) begin
          state_d = S_UP_MISS;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.hmatch) begin
          cmd_o.hit = 1'b1;
          state_d = S_UP_WR;
        end else begin
          cmd_o.inc = 1'b1;
          state_d = S_UP_RD;
        end
      end
      S_UP_MISS: begin
        priority if (sts_i.free_nz) begin
          cmd_o.pop = 1'b1;
          state_d = S_UP_POP;
        end else if (sts_i.can_grow) begin
          cmd_o.grow = 1'b1;
          state_d = S_UP_WR;
        end else begin
          state_d = S_REJ;
        end
      end
      S_UP_POP: begin
        cmd_o.pop_take = 1'b1;
        state_d = S_UP_WR;
      end
      S_UP_WR: begin
        if (sts_i.out_free) begin
          cmd_o.up_wr = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REJ: begin
        if (sts_i.out_free) begin
          cmd_o.emit_rej = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ES_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d = S_ES_RD;
      end
      S_ES_RD: begin
        if (sts_i.scan_done) begin
          cmd_o.cnt_init = 1'b1;
          state_d = S_ES_CNT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_ES_CHK;
        end
      end
      S_ES_CHK: begin
        cmd_o.es_chk = 1'b1;
        state_d = S_ES_RD;
      end
      S_ES_CNT: begin
        if (sts_i.at_end) begin
          state_d = S_ES_DEC;
        end else begin
          cmd_o.cnt_step = 1'b1;
        end
      end
      S_ES_DEC: begin
        if (sts_i.total_zero) begin
          state_d = S_ES_NONE;
        end else begin
          cmd_o.run_init = 1'b1;
          state_d = S_ES_RUN;
        end
      end
      S_ES_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_none = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ES_RUN: begin
        if (sts_i.run_end) begin
          state_d = S_ES_FLUSH;
        end else if (sts_i.out_free) begin
          cmd_o.run_step = 1'b1;
        end
      end
      S_ES_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tst_dp.sv =====
// ----------------------------------------------------------------------------
// tst_dp: texture slot table datapath
// Handle, touch-frame and free-stack RAMs, dirty marks, counters, the
// scan index, run builder and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_dp import tst_pkg::*; #(
  parameter int SLOTS       = DefSlots,
  parameter int HANDLE_BITS = DefHandleBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  in_t                    fld_q;
  logic [FrameW-1:0]      frame_q;
  logic [CW-1:0]          used_q, free_q, idx_q, total_q, len_q, pend_cnt_q;
  logic [IW-1:0]          slot_q, first_q, pend_first_q;
  logic [SLOTS-1:0]       dirty_q;
  logic [RunCntW-1:0]     runs_q;
  logic                   new_q, pend_v_q, out_valid_q;
  out_t                   out_q;

  logic [HANDLE_BITS-1:0] key;
  logic [HANDLE_BITS-1:0] hnd_rd, hnd_wdata;
  logic [FrameW-1:0]      tch_rd, tch_wdata;
  logic [IW-1:0]          stk_rd, idx_ix, free_m1, hnd_waddr;
  logic                   hnd_we, tch_we, stk_we, stale, out_free, cur_d, out_set;
  logic [CW-1:0]          free_m1_w;

  always_comb begin
    for (int b = 0; b < HANDLE_BITS; b++) begin
      key[b] = (b < HandleW) ? fld_q.handle[b % HandleW] : 1'b0;
    end
  end

  assign idx_ix    = idx_q[IW-1:0];
  assign free_m1_w = free_q - CW'(1);
  assign free_m1   = free_m1_w[IW-1:0];
  assign stale     = (tch_rd != frame_q) && (hnd_rd != '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign cur_d     = (idx_q < SlotsC) && dirty_q[idx_ix];
  assign out_set   = cmd_i.do_begin || cmd_i.do_clear || cmd_i.up_wr || cmd_i.emit_rej ||
                     cmd_i.emit_none || cmd_i.emit_flush ||
                     (cmd_i.run_step && !cur_d && (len_q != '0) &&
                      (runs_q < RunCntW'(MaxRuns)) && pend_v_q);

  always_comb begin
    hnd_we    = (cmd_i.up_wr && new_q) || (cmd_i.es_chk && stale);
    tch_we    = cmd_i.up_wr || (cmd_i.es_chk && stale);
    stk_we    = cmd_i.es_chk && stale && (free_q < SlotsC);
    hnd_waddr = cmd_i.up_wr ? slot_q : idx_ix;
    hnd_wdata = cmd_i.up_wr ? key : '0;
    tch_wdata = cmd_i.up_wr ? frame_q : '0;
  end

  tst_ram #(.Width(HANDLE_BITS), .Depth(SLOTS)) u_hnd_ram (
    .clk_i, .we_i(hnd_we), .waddr_i(hnd_waddr), .wdata_i(hnd_wdata),
    .raddr_i(idx_ix), .rdata_o(hnd_rd)
  );

  tst_ram #(.Width(FrameW), .Depth(SLOTS)) u_tch_ram (
    .clk_i, .we_i(tch_we), .waddr_i(hnd_waddr), .wdata_i(tch_wdata),
    .raddr_i(idx_ix), .rdata_o(tch_rd)
  );

  tst_ram #(.Width(IW), .Depth(SLOTS)) u_stk_ram (
    .clk_i, .we_i(stk_we), .waddr_i(free_q[IW-1:0]), .wdata_i(idx_ix),
    .raddr_i(free_m1), .rdata_o(stk_rd)
  );

  always_comb begin
    sts_o            = '0;
    sts_o.up_bad     = (key == '0) || !fld_q.handle_valid;
    sts_o.scan_done  = idx_q >= used_q;
    sts_o.hmatch     = hnd_rd == key;
    sts_o.free_nz    = free_q != '0;
    sts_o.can_grow   = used_q < SlotsC;
    sts_o.at_end     = idx_q == SlotsC;
    sts_o.total_zero = total_q == '0;
    sts_o.run_end    = (idx_q == SlotsC) && (len_q == '0);
    sts_o.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      used_q   <= CW'(1);
      free_q   <= '0;
      dirty_q  <= '0;
      idx_q    <= '0;
      total_q  <= '0;
      len_q    <= '0;
      runs_q   <= '0;
      pend_v_q <= 1'b0;
      new_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.do_begin) begin
        frame_q <= fld_q.frame_number;
        dirty_q <= '0;
      end
      if (cmd_i.do_clear) begin
        frame_q <= '0;
        used_q  <= CW'(1);
        free_q  <= '0;
        dirty_q <= '0;
      end
      if (cmd_i.scan_init) begin
        idx_q <= CW'(1);
        new_q <= 1'b1;
      end
      if (cmd_i.inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.hit) begin
        new_q <= 1'b0;
      end
      if (cmd_i.pop) begin
        free_q <= free_m1_w;
      end
      if (cmd_i.grow) begin
        used_q <= used_q + CW'(1);
      end
      if (cmd_i.up_wr && (new_q || fld_q.force_dirty)) begin
        dirty_q[slot_q] <= 1'b1;
      end
      if (cmd_i.es_chk) begin
        idx_q <= idx_q + CW'(1);
        if (stale) begin
          dirty_q[idx_ix] <= 1'b1;
          if (free_q < SlotsC) begin
            free_q <= free_q + CW'(1);
          end
        end
      end
      if (cmd_i.cnt_init) begin
        idx_q   <= '0;
        total_q <= '0;
      end
      if (cmd_i.cnt_step) begin
        idx_q <= idx_q + CW'(1);
        if (dirty_q[idx_ix]) begin
          total_q <= total_q + CW'(1);
        end
      end
      if (cmd_i.run_init) begin
        idx_q    <= '0;
        len_q    <= '0;
        runs_q   <= '0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.run_step) begin
        if (idx_q != SlotsC) begin
          idx_q <= idx_q + CW'(1);
        end
        if (cur_d) begin
          len_q <= len_q + CW'(1);
        end else if (len_q != '0) begin
          len_q <= '0;
          if (runs_q < RunCntW'(MaxRuns)) begin
            runs_q   <= runs_q + RunCntW'(1);
            pend_v_q <= 1'b1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      fld_q <= in_data_i;
    end
    if (cmd_i.hit) begin
      slot_q <= idx_ix;
    end
    if (cmd_i.grow) begin
      slot_q <= used_q[IW-1:0];
    end
    if (cmd_i.pop_take) begin
      slot_q <= stk_rd;
    end
    if (cmd_i.run_step) begin
      if (cur_d && (len_q == '0)) begin
        first_q <= idx_ix;
      end
      if (!cur_d && (len_q != '0) && (runs_q < RunCntW'(MaxRuns))) begin
        pend_first_q <= first_q;
        pend_cnt_q   <= len_q;
        if (pend_v_q) begin
          out_q <= '{K_RANGE, '0, FieldW'(pend_first_q), FieldW'(pend_cnt_q),
                     FieldW'(total_q), 1'b0};
        end
      end
    end
    if (cmd_i.do_begin || cmd_i.do_clear) begin
      out_q <= '{K_ACK, '0, '0, '0, '0, 1'b1};
    end
    if (cmd_i.emit_rej) begin
      out_q <= '{K_REJECT, '0, '0, '0, '0, 1'b1};
    end
    if (cmd_i.up_wr) begin
      out_q <= '{K_INDEX, FieldW'(slot_q), '0, '0, '0, 1'b1};
    end
    if (cmd_i.emit_none) begin
      out_q <= '{K_RANGE, '0, '0, '0, '0, 1'b1};
    end
    if (cmd_i.emit_flush) begin
      out_q <= '{K_RANGE, '0, FieldW'(pend_first_q), FieldW'(pend_cnt_q),
                 FieldW'(total_q), 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_texture_slot_table_with_dirty_ranges_core.sv =====
// ----------------------------------------------------------------------------
// tb_texture_slot_table_with_dirty_ranges_core: slot table testbench
// Drives begin/upsert/end/clear words from a queue with random idling, keeps
// its own slot table model and compares every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_texture_slot_table_with_dirty_ranges_core;
  import tst_pkg::*;

  localparam int NSlots = 64;
  localparam int StallLimit = 200000;
  localparam int HoldStart = 1500;
  localparam int HoldLen = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  texture_slot_table_with_dirty_ranges_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // table model
  logic [31:0] tbl_handle [NSlots];
  logic [31:0] tbl_frame [NSlots];
  logic tbl_dirty [NSlots];
  logic [5:0] free_lifo [NSlots];
  int free_cnt;
  int in_use;
  logic [31:0] cur_frame;

  in_t pending_words[$];
  out_t expected_words[$];
  int mismatches = 0;
  int in_cycle = 0;
  int idle_pct_in = 17, idle_pct_out = 17;
  int hold_off = 0;
  int watchdog = 0;

  function automatic void add_item(in_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void add_expect(out_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic out_t mk(kind_e k, int s, int f, int c, int t, int l);
    out_t r;
    r.kind = k; r.slot_index = FieldW'(s); r.range_first = FieldW'(f);
    r.range_count = FieldW'(c); r.dirty_total = FieldW'(t); r.last = l[0];
    return r;
  endfunction

  task automatic table_reset();
    for (int i = 0; i < NSlots; i++) begin
      tbl_handle[i] = '0; tbl_frame[i] = '0; tbl_dirty[i] = 0; free_lifo[i] = '0;
    end
    free_cnt = 0; in_use = 1; cur_frame = '0;
  endtask

  task automatic predict_table(in_t w);
    int idx, tot, rf, rl, nr;
    bit hit;
    out_t runs[$];
    case (w.op)
      OP_BEGIN: begin
        cur_frame = w.frame_number;
        for (int i = 0; i < NSlots; i++) tbl_dirty[i] = 0;
        tbl_frame[0] = cur_frame;
        add_expect(mk(K_ACK, 0, 0, 0, 0, 1));
      end
      OP_UPSERT: begin
        hit = 0; idx = 0;
        if (w.handle == '0 || !w.handle_valid) begin
          add_expect(mk(K_REJECT, 0, 0, 0, 0, 1));
          return;
        end
        for (int i = 1; i < in_use; i++)
          if (!hit && tbl_handle[i] == w.handle) begin
            idx = i; hit = 1;
          end
        if (!hit) begin
          if (free_cnt > 0) begin
            free_cnt--; idx = int'(free_lifo[free_cnt]);
          end else if (in_use < NSlots) begin
            idx = in_use; in_use++;
          end else begin
            add_expect(mk(K_REJECT, 0, 0, 0, 0, 1));
            return;
          end
          tbl_handle[idx] = w.handle;
        end
        tbl_frame[idx] = cur_frame;
        if (!hit || w.force_dirty) tbl_dirty[idx] = 1;
        add_expect(mk(K_INDEX, idx, 0, 0, 0, 1));
      end
      OP_END: begin
        tot = 0; rl = 0; rf = 0;
        for (int i = 1; i < in_use; i++)
          if (tbl_frame[i] != cur_frame && tbl_handle[i] != '0) begin
            tbl_handle[i] = '0; tbl_frame[i] = '0;
            if (free_cnt < NSlots) begin
              free_lifo[free_cnt] = 6'(i); free_cnt++;
            end
            tbl_dirty[i] = 1;
          end
        for (int i = 0; i < NSlots; i++) if (tbl_dirty[i]) tot++;
        if (tot == 0) begin
          add_expect(mk(K_RANGE, 0, 0, 0, 0, 1));
          return;
        end
        for (int i = 0; i <= NSlots; i++) begin
          if (i < NSlots && tbl_dirty[i]) begin
            if (rl == 0) rf = i;
            rl++;
          end else if (rl > 0) begin
            if (runs.size() < MaxRuns) runs.insert(runs.size(), mk(K_RANGE, 0, rf, rl, tot, 0));
            rl = 0;
          end
        end
        nr = runs.size();
        runs[nr-1].last = 1;
        foreach (runs[j]) add_expect(runs[j]);
      end
      default: begin
        table_reset();
        add_expect(mk(K_ACK, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  function automatic in_t word(op_e op, logic [31:0] h, int v, int fd, logic [31:0] fr);
    in_t w;
    w.op = op; w.handle = h; w.handle_valid = v[0]; w.force_dirty = fd[0];
    w.frame_number = fr;
    return w;
  endfunction

  function automatic logic [31:0] rnd_handle(int pool);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, pool);
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    in_cycle <= in_cycle + 1;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) predict_table(in_data_i);
        if (pending_words.size() > 0 &&
            (in_cycle % 1000 < 300 || $urandom_range(0, 99) >= idle_pct_in)) begin
          in_data_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          in_data_i <= '0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (in_cycle == HoldStart) hold_off <= HoldLen;
    else if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_data_o);
        end else begin
          out_t e;
          e = expected_words.pop_front();
          if (e !== out_data_o) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_data_o);
          end
        end
      end
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (in_cycle % 1000 < 300) || ($urandom_range(0, 99) >= idle_pct_out);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog > StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int pool;
    logic [31:0] fr;
    table_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    add_item(word(OP_END, 0, 0, 0, 0));
    add_item(word(OP_BEGIN, 0, 0, 0, 32'd1));
    add_item(word(OP_UPSERT, 0, 1, 0, 0));
    add_item(word(OP_UPSERT, 32'd5, 0, 1, 0));
    add_item(word(OP_UPSERT, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF));
    add_item(word(OP_UPSERT, 32'd1, 1, 0, 0));
    add_item(word(OP_UPSERT, 32'd1, 1, 1, 0));
    add_item(word(OP_UPSERT, 32'hAAAA_5555, 1, 0, 0));
    add_item(word(OP_END, 0, 0, 0, 0));
    add_item(word(OP_END, 0, 0, 0, 0));
    add_item(word(OP_BEGIN, 0, 0, 0, 32'hFFFF_FFFF));
    add_item(word(OP_UPSERT, 32'd1, 1, 0, 0));
    add_item(word(OP_END, 0, 0, 0, 0));
    add_item(word(OP_UPSERT, 32'd77, 1, 0, 0));
    add_item(word(OP_CLEAR, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF));
    // fill the table to full, then one more
    for (int i = 1; i <= 64; i++) add_item(word(OP_UPSERT, i, 1, 0, 0));
    add_item(word(OP_UPSERT, 32'd1, 1, 1, 0));
    add_item(word(OP_END, 0, 0, 0, 0));
    add_item(word(OP_BEGIN, 0, 0, 0, 32'd9));
    for (int i = 2; i <= 60; i += 3) add_item(word(OP_UPSERT, i, 1, 0, 0));
    add_item(word(OP_END, 0, 0, 0, 0));
    // random frames
    fr = 32'd10;
    while (pending_words.size() < 360) begin
      pool = ($urandom_range(0, 3) == 0) ? 90 : 30;
      if ($urandom_range(0, 29) == 0) add_item(word(OP_CLEAR,
          $urandom(), $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
      fr = ($urandom_range(0, 9) == 0) ? $urandom() : fr + 1;
      add_item(word(OP_BEGIN, $urandom(), $urandom_range(0, 1),
          $urandom_range(0, 1), fr));
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 7) == 0)
          add_item(word(op_e'($urandom_range(0, 3)), rnd_handle(pool),
              $urandom_range(0, 1), $urandom_range(0, 1), $urandom()));
        else
          add_item(word(OP_UPSERT, rnd_handle(pool),
              ($urandom_range(0, 9) != 0) ? 1 : 0, $urandom_range(0, 1), $urandom()));
      end
      add_item(word(OP_END, $urandom(), $urandom_range(0, 1),
          $urandom_range(0, 1), $urandom()));
    end
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_words.size() == 0);
    repeat (500) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
